>>> rtl/kbsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbsc_pkg
// Shared types, codes and keyword tables of the keyword-blind stream compare.
// ----------------------------------------------------------------------------
package kbsc_pkg;

    // compare modes
    localparam logic [1:0] MODE_EXACT   = 2'd0;
    localparam logic [1:0] MODE_KEYWORD = 2'd1;
    localparam logic [1:0] MODE_MARKER  = 2'd2;

    // input commands
    localparam logic [1:0] CMD_BYTE_A = 2'd0;
    localparam logic [1:0] CMD_BYTE_B = 2'd1;
    localparam logic [1:0] CMD_END_A  = 2'd2;
    localparam logic [1:0] CMD_END_B  = 2'd3;

    // status codes
    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_SAME = 2'd1;
    localparam logic [1:0] ST_DIFF = 2'd2;
    localparam logic [1:0] ST_OVF  = 2'd3;

    localparam logic [8:0] SYM_TAG_BASE = 9'h100;

    // request from the scanner to the alignment queue
    typedef struct packed {
        logic       valid;
        logic       is_end;
        logic       file;
        logic [8:0] sym;
    } align_req_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [1:0] ended;
    } align_stat_t;

    // keyword text, first character in the top byte, padded with spaces
    function automatic logic [63:0] kw_word(input logic [2:0] k);
        logic [63:0] w;
        case (k)
            3'd0:    w = "Log     ";
            3'd1:    w = "Id      ";
            3'd2:    w = "Revision";
            3'd3:    w = "Source  ";
            3'd4:    w = "Author  ";
            3'd5:    w = "Date    ";
            3'd6:    w = "State   ";
            3'd7:    w = "Header  ";
            default: w = "        ";
        endcase
        return w;
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] i);
        logic [63:0] w;
        w = kw_word(k);
        return w[(7 - i) * 8 +: 8];
    endfunction

    function automatic logic [3:0] kw_len(input logic [2:0] k);
        logic [3:0] n;
        case (k)
            3'd0:    n = 4'd3;
            3'd1:    n = 4'd2;
            3'd2:    n = 4'd8;
            3'd3:    n = 4'd6;
            3'd4:    n = 4'd6;
            3'd5:    n = 4'd4;
            3'd6:    n = 4'd5;
            3'd7:    n = 4'd6;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    // seven-byte line marker
    function automatic logic [7:0] mark_char(input logic [2:0] i);
        logic [7:0] c;
        case (i)
            3'd0:    c = 8'h42;
            3'd1:    c = 8'h4B;
            3'd2:    c = 8'h20;
            3'd3:    c = 8'h49;
            3'd4:    c = 8'h64;
            3'd5:    c = 8'h3A;
            3'd6:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/kbsc_align.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbsc_align
// Alignment queue: holds the symbols of the leading file and matches the
// other file's symbols against them; keeps verdict and end flags.
// ----------------------------------------------------------------------------
module kbsc_align #(
    parameter int DEPTH = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  clear_i,
    input  kbsc_pkg::align_req_t  req_i,
    output logic                  done_o,
    output kbsc_pkg::align_stat_t stat_o
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {A_IDLE, A_POP} align_state_t;

    align_state_t   state_reg;
    logic [8:0]     queue_mem [DEPTH];
    logic [8:0]     q_reg;
    logic [8:0]     sym_reg;
    logic [AW-1:0]  head_reg;
    logic [AW-1:0]  tail_reg;
    logic [CW-1:0]  count_reg;
    logic           ahead_reg;
    logic [1:0]     ended_reg;
    logic [1:0]     verdict_reg;
    logic           done_reg;
    logic [1:0]     ended_next;
    logic           push_ok;

    always_comb begin
        ended_next = ended_reg | (2'b01 << req_i.file);
        push_ok    = (count_reg == '0) || (ahead_reg == req_i.file);
    end

    always_ff @(posedge aclk) begin
        q_reg <= queue_mem[head_reg];
        if (state_reg == A_IDLE && req_i.valid && !req_i.is_end && verdict_reg == kbsc_pkg::ST_BUSY
            && push_ok && !ended_reg[~req_i.file] && count_reg != CW'(DEPTH)) begin
            queue_mem[tail_reg] <= req_i.sym;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear_i) begin
            state_reg   <= A_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            ahead_reg   <= 1'b0;
            ended_reg   <= 2'b00;
            verdict_reg <= kbsc_pkg::ST_BUSY;
            done_reg    <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                A_IDLE: begin
                    if (req_i.valid) begin
                        sym_reg <= req_i.sym;
                        if (req_i.is_end) begin
                            ended_reg <= ended_next;
                            done_reg  <= 1'b1;
                            if (verdict_reg == kbsc_pkg::ST_BUSY) begin
                                if (ended_next == 2'b11) begin
                                    verdict_reg <= (count_reg == '0) ? kbsc_pkg::ST_SAME
                                                                     : kbsc_pkg::ST_DIFF;
                                end else if (count_reg != '0 && ahead_reg != req_i.file) begin
                                    verdict_reg <= kbsc_pkg::ST_DIFF;
                                end
                            end
                        end else if (verdict_reg != kbsc_pkg::ST_BUSY) begin
                            done_reg <= 1'b1;
                        end else if (push_ok) begin
                            done_reg <= 1'b1;
                            if (ended_reg[~req_i.file]) begin
                                verdict_reg <= kbsc_pkg::ST_DIFF;
                            end else if (count_reg == CW'(DEPTH)) begin
                                verdict_reg <= kbsc_pkg::ST_OVF;
                            end else begin
                                tail_reg  <= (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                                count_reg <= count_reg + 1'b1;
                                ahead_reg <= req_i.file;
                            end
                        end else begin
                            // head entry is being read this cycle
                            state_reg <= A_POP;
                        end
                    end
                end
                A_POP: begin
                    if (q_reg != sym_reg) begin
                        verdict_reg <= kbsc_pkg::ST_DIFF;
                    end
                    head_reg  <= (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    count_reg <= count_reg - 1'b1;
                    done_reg  <= 1'b1;
                    state_reg <= A_IDLE;
                end
                default: begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign done_o         = done_reg;
    assign stat_o.verdict = verdict_reg;
    assign stat_o.ended   = ended_reg;

    a_verdict_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (verdict_reg != kbsc_pkg::ST_BUSY && !clear_i) |=> verdict_reg == $past(verdict_reg))
        else $error("verdict changed after being decided");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with head and tail apart");

    a_done_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> ($past(req_i.valid) || $past(state_reg == A_POP)))
        else $error("done without a request");

endmodule

>>> rtl/kbsc_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbsc_scan
// Per-file canonical scanner and item sequencer. Bytes of each file are kept
// in a ring memory so that a failed keyword tag can be scanned again.
// ----------------------------------------------------------------------------
module kbsc_scan #(
    parameter int TAG_LIMIT = 512
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  clear_i,
    input  logic [1:0]            mode_i,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_cmd,
    input  logic [7:0]            in_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            out_status,
    output kbsc_pkg::align_req_t  req_o,
    input  logic                  done_i,
    input  kbsc_pkg::align_stat_t stat_i
);

    // ring per file, larger than the longest tag window
    localparam int RW = $clog2(TAG_LIMIT + 2);

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;

    typedef enum logic [3:0] {
        PH_TEXT, PH_NAME, PH_AFTER, PH_BODY, PH_LOGREST,
        PH_LINESTART, PH_LSP, PH_LSTAR, PH_MSKIP
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE, S_FETCH, S_DATA, S_EMIT, S_EWAIT, S_FAILRD, S_FAILEM,
        S_FAILWAIT, S_ENDREQ, S_ENDWAIT, S_RESP
    } scan_state_t;

    scan_state_t state_reg;
    scan_state_t ret_reg;

    logic [7:0]    ring_mem [2 * (2 ** RW)];
    logic [7:0]    ring_q;
    logic [RW:0]   ring_raddr;

    phase_t        phase_reg  [2];
    logic [7:0]    match_reg  [2];
    logic [1:0]    lit_reg    [2];
    logic [RW-1:0] tstart_reg [2];
    logic [RW-1:0] wr_reg     [2];

    logic          f_reg;
    logic          end_reg;
    logic [RW-1:0] rd_reg;
    logic [RW-1:0] pos_reg;
    logic [8:0]    esym0_reg;
    logic [8:0]    esym1_reg;
    logic [1:0]    ecnt_reg;
    logic [1:0]    fcnt_reg;
    logic [1:0]    fm_reg;
    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    kbsc_pkg::align_req_t req_reg;

    phase_t        cur_phase;
    logic [7:0]    cur_match;
    logic [RW-1:0] cur_ts;
    logic [RW-1:0] cur_wr;
    logic [RW-1:0] pend;
    logic [RW-1:0] q_idx;
    logic [7:0]    nm;
    logic          name_hit;
    logic [2:0]    name_k;
    logic [RW-1:0] total_cur;
    logic [RW-1:0] total_end;
    logic [1:0]    fm_cur;
    logic [1:0]    fm_end;
    logic          in_f;
    logic          in_is_end;
    logic [7:0]    b;

    always_comb begin
        cur_phase = phase_reg[f_reg];
        cur_match = match_reg[f_reg];
        cur_ts    = tstart_reg[f_reg];
        cur_wr    = wr_reg[f_reg];
        b         = ring_q;
        pend      = pos_reg - cur_ts;
        q_idx     = pend - 1'b1;
        nm        = '0;
        name_hit  = 1'b0;
        name_k    = '0;
        for (int k = 0; k < 8; k++) begin
            if (cur_match[k] && q_idx < RW'(kbsc_pkg::kw_len(3'(k)))
                && kbsc_pkg::kw_char(3'(k), q_idx[2:0]) == b) begin
                nm[k] = 1'b1;
            end
        end
        for (int k = 0; k < 8; k++) begin
            if (nm[k] && RW'(kbsc_pkg::kw_len(3'(k))) == pend) begin
                name_hit = 1'b1;
                name_k   = 3'(k);
            end
        end
        total_cur = pos_reg + 1'b1 - cur_ts;
        total_end = cur_wr - cur_ts;
        fm_cur    = (total_cur >= RW'(3)) ? 2'd3 : total_cur[1:0];
        fm_end    = (total_end >= RW'(3)) ? 2'd3 : total_end[1:0];
        in_f      = in_cmd[0];
        in_is_end = (in_cmd == kbsc_pkg::CMD_END_A) || (in_cmd == kbsc_pkg::CMD_END_B);
        if (state_reg == S_FAILRD) begin
            ring_raddr = {f_reg, cur_ts + RW'(fcnt_reg)};
        end else begin
            ring_raddr = {f_reg, rd_reg};
        end
    end

    always_ff @(posedge aclk) begin
        ring_q <= ring_mem[ring_raddr];
        if (state_reg == S_IDLE && in_valid && !in_is_end && mode_i == kbsc_pkg::MODE_KEYWORD) begin
            ring_mem[{in_f, wr_reg[in_f]}] <= in_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear_i) begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_RESP;
            req_reg       <= '0;
            for (int i = 0; i < 2; i++) begin
                phase_reg[i]  <= PH_TEXT;
                match_reg[i]  <= '0;
                lit_reg[i]    <= '0;
                tstart_reg[i] <= '0;
                wr_reg[i]     <= '0;
            end
            ecnt_reg      <= '0;
            fcnt_reg      <= '0;
            end_reg       <= 1'b0;
            f_reg         <= 1'b0;
            rd_reg        <= '0;
            if (!aresetn) begin
                out_valid_reg <= 1'b0;
            end
        end else begin
            req_reg.valid <= 1'b0;
            if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        f_reg    <= in_f;
                        end_reg  <= in_is_end;
                        rd_reg   <= wr_reg[in_f];
                        ret_reg  <= S_RESP;
                        ecnt_reg <= '0;
                        esym0_reg <= {1'b0, in_byte};
                        if (stat_i.verdict != kbsc_pkg::ST_BUSY || stat_i.ended[in_f]) begin
                            state_reg <= S_RESP;
                        end else if (in_is_end) begin
                            state_reg <= (mode_i == kbsc_pkg::MODE_KEYWORD) ? S_FETCH : S_ENDREQ;
                        end else if (mode_i == kbsc_pkg::MODE_KEYWORD) begin
                            wr_reg[in_f] <= wr_reg[in_f] + 1'b1;
                            state_reg    <= S_FETCH;
                        end else if (mode_i == kbsc_pkg::MODE_MARKER) begin
                            state_reg <= S_EMIT;
                            if (phase_reg[in_f] == PH_MSKIP) begin
                                if (in_byte == CH_NL) begin
                                    ecnt_reg         <= 2'd1;
                                    phase_reg[in_f]  <= PH_TEXT;
                                    match_reg[in_f]  <= '0;
                                end
                            end else begin
                                ecnt_reg        <= 2'd1;
                                phase_reg[in_f] <= PH_TEXT;
                                if (match_reg[in_f] < 8'd7
                                    && in_byte == kbsc_pkg::mark_char(match_reg[in_f][2:0])) begin
                                    if (match_reg[in_f] == 8'd6) begin
                                        phase_reg[in_f] <= PH_MSKIP;
                                        match_reg[in_f] <= '0;
                                    end else begin
                                        match_reg[in_f] <= match_reg[in_f] + 1'b1;
                                    end
                                end else begin
                                    match_reg[in_f] <= (in_byte == kbsc_pkg::mark_char(3'd0))
                                                       ? 8'd1 : 8'd0;
                                end
                            end
                        end else begin
                            ecnt_reg  <= 2'd1;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_FETCH: begin
                    if (rd_reg != cur_wr) begin
                        pos_reg   <= rd_reg;
                        rd_reg    <= rd_reg + 1'b1;
                        state_reg <= S_DATA;
                    end else if (!end_reg) begin
                        state_reg <= S_RESP;
                    end else if (cur_phase == PH_NAME || cur_phase == PH_AFTER
                                 || cur_phase == PH_BODY) begin
                        // file ended inside a tag
                        fm_reg    <= fm_end;
                        fcnt_reg  <= '0;
                        state_reg <= S_FAILRD;
                    end else begin
                        esym0_reg <= {1'b0, CH_SPACE};
                        esym1_reg <= {1'b0, CH_STAR};
                        ecnt_reg  <= (cur_phase == PH_LSP) ? 2'd1 :
                                     (cur_phase == PH_LSTAR) ? 2'd2 : 2'd0;
                        ret_reg   <= S_ENDREQ;
                        state_reg <= S_EMIT;
                    end
                end
                S_DATA: begin
                    ret_reg   <= S_FETCH;
                    ecnt_reg  <= '0;
                    esym0_reg <= {1'b0, b};
                    esym1_reg <= {1'b0, CH_STAR};
                    state_reg <= S_EMIT;
                    fm_reg    <= fm_cur;
                    fcnt_reg  <= '0;
                    case (cur_phase)
                        PH_NAME: begin
                            if (nm == '0) begin
                                state_reg <= S_FAILRD;
                            end else if (name_hit) begin
                                match_reg[f_reg] <= {5'd0, name_k};
                                phase_reg[f_reg] <= PH_AFTER;
                            end else begin
                                match_reg[f_reg] <= nm;
                            end
                        end
                        PH_AFTER: begin
                            if (b == CH_DOLLAR) begin
                                esym0_reg        <= kbsc_pkg::SYM_TAG_BASE + 9'(cur_match[2:0]);
                                ecnt_reg         <= 2'd1;
                                lit_reg[f_reg]   <= '0;
                                phase_reg[f_reg] <= PH_TEXT;
                            end else if (b == CH_COLON) begin
                                phase_reg[f_reg] <= PH_BODY;
                            end else begin
                                state_reg <= S_FAILRD;
                            end
                        end
                        PH_BODY: begin
                            if (b == CH_NL) begin
                                state_reg <= S_FAILRD;
                            end else if (b == CH_DOLLAR) begin
                                esym0_reg        <= kbsc_pkg::SYM_TAG_BASE + 9'(cur_match[2:0]);
                                ecnt_reg         <= 2'd1;
                                lit_reg[f_reg]   <= '0;
                                phase_reg[f_reg] <= (cur_match == 8'd0) ? PH_LOGREST : PH_TEXT;
                            end else if (pend >= RW'(TAG_LIMIT)) begin
                                state_reg <= S_FAILRD;
                            end
                        end
                        PH_LOGREST: begin
                            if (b == CH_NL) begin
                                phase_reg[f_reg] <= PH_LINESTART;
                            end
                        end
                        PH_LINESTART: begin
                            if (b == CH_HASH) begin
                                phase_reg[f_reg] <= PH_LOGREST;
                            end else if (b == CH_SPACE) begin
                                phase_reg[f_reg] <= PH_LSP;
                            end else begin
                                phase_reg[f_reg] <= PH_TEXT;
                                rd_reg           <= pos_reg;
                            end
                        end
                        PH_LSP: begin
                            if (b == CH_STAR) begin
                                phase_reg[f_reg] <= PH_LSTAR;
                            end else begin
                                esym0_reg        <= {1'b0, CH_SPACE};
                                ecnt_reg         <= 2'd1;
                                phase_reg[f_reg] <= PH_TEXT;
                                rd_reg           <= pos_reg;
                            end
                        end
                        PH_LSTAR: begin
                            if (b == CH_SLASH) begin
                                esym0_reg        <= {1'b0, CH_SPACE};
                                ecnt_reg         <= 2'd2;
                                phase_reg[f_reg] <= PH_TEXT;
                                rd_reg           <= pos_reg;
                            end else if (b == CH_NL) begin
                                phase_reg[f_reg] <= PH_LINESTART;
                            end else begin
                                phase_reg[f_reg] <= PH_LOGREST;
                            end
                        end
                        default: begin
                            phase_reg[f_reg] <= PH_TEXT;
                            if (lit_reg[f_reg] != 2'd0) begin
                                lit_reg[f_reg] <= lit_reg[f_reg] - 1'b1;
                                ecnt_reg       <= 2'd1;
                            end else if (b == CH_DOLLAR) begin
                                tstart_reg[f_reg] <= pos_reg;
                                match_reg[f_reg]  <= 8'hFF;
                                phase_reg[f_reg]  <= PH_NAME;
                            end else begin
                                ecnt_reg <= 2'd1;
                            end
                        end
                    endcase
                end
                S_EMIT: begin
                    if (ecnt_reg == 2'd0) begin
                        state_reg <= ret_reg;
                    end else begin
                        req_reg   <= '{valid: 1'b1, is_end: 1'b0, file: f_reg, sym: esym0_reg};
                        state_reg <= S_EWAIT;
                    end
                end
                S_EWAIT: begin
                    if (done_i) begin
                        esym0_reg <= esym1_reg;
                        ecnt_reg  <= ecnt_reg - 1'b1;
                        state_reg <= S_EMIT;
                    end
                end
                S_FAILRD: begin
                    if (fcnt_reg == fm_reg) begin
                        // first bytes of the tag went out plain; rescan the rest
                        rd_reg           <= cur_ts + RW'(fm_reg);
                        lit_reg[f_reg]   <= 2'd3 - fm_reg;
                        phase_reg[f_reg] <= PH_TEXT;
                        match_reg[f_reg] <= '0;
                        state_reg        <= S_FETCH;
                    end else begin
                        state_reg <= S_FAILEM;
                    end
                end
                S_FAILEM: begin
                    req_reg   <= '{valid: 1'b1, is_end: 1'b0, file: f_reg, sym: {1'b0, ring_q}};
                    fcnt_reg  <= fcnt_reg + 1'b1;
                    state_reg <= S_FAILWAIT;
                end
                S_FAILWAIT: begin
                    if (done_i) begin
                        state_reg <= S_FAILRD;
                    end
                end
                S_ENDREQ: begin
                    phase_reg[f_reg] <= PH_TEXT;
                    req_reg   <= '{valid: 1'b1, is_end: 1'b1, file: f_reg, sym: 9'd0};
                    state_reg <= S_ENDWAIT;
                end
                S_ENDWAIT: begin
                    if (done_i) begin
                        state_reg <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (!out_valid_reg || out_ready) begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= stat_i.verdict;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign req_o      = req_reg;

    a_tag_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_phase == PH_NAME || cur_phase == PH_AFTER || cur_phase == PH_BODY)
        |-> (cur_wr - cur_ts) <= RW'(TAG_LIMIT + 1))
        else $error("tag window exceeds ring");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transfer taken while busy");

endmodule

>>> rtl/keyword_blind_stream_compare_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_blind_stream_compare_core
// Compares two byte streams, optionally blind to keyword tags or marked lines.
// ----------------------------------------------------------------------------
// Each accepted transfer carries one command and returns one status transfer.
// Items are handled one at a time. In exact and marker mode a byte's symbol
// goes straight to the alignment queue; when it is matched against the queue
// head, the registered queue read adds the A_POP state. In keyword mode a byte
// is first written to the per-file ring memory and read back through its
// registered read port. A byte that yields no symbol, or any item after the
// verdict is decided, finishes sooner. A failed keyword tag releases up to
// three of its first bytes plain and rescans the rest from the ring.
// The next command is accepted while a result still waits.
// There is no clearing pass after reset; writing compare_mode restarts the
// comparison at once.
module keyword_blind_stream_compare_core #(
    parameter int TAG_LIMIT   = 512,
    parameter int ALIGN_DEPTH = 4096
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [1:0] s_tuser,   // [1:0] command
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [1:0] status, [7:2] zero
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data   // [1:0] compare_mode
);

    logic                  [1:0] mode_reg;
    logic                        cfg_write;
    logic                  [1:0] status;
    kbsc_pkg::align_req_t        req;
    kbsc_pkg::align_stat_t       stat;
    logic                        done;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= kbsc_pkg::MODE_EXACT;
        end else if (cfg_write) begin
            mode_reg <= cfg_data;
        end
    end

    kbsc_scan #(
        .TAG_LIMIT (TAG_LIMIT)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear_i    (cfg_write),
        .mode_i     (mode_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .in_byte    (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (status),
        .req_o      (req),
        .done_i     (done),
        .stat_i     (stat)
    );

    kbsc_align #(
        .DEPTH (ALIGN_DEPTH)
    ) u_align (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear_i (cfg_write),
        .req_i   (req),
        .done_o  (done),
        .stat_o  (stat)
    );

    assign m_tdata = {6'd0, status};

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyword-blind stream compare core. Pairs of
// files are built from plain text, keyword tags, Log comment blocks and
// marked lines, then sent interleaved under every compare mode. A behavioural
// copy of the comparator predicts each status transfer.
// ----------------------------------------------------------------------------
module tb;

    localparam int TAG_MAX   = 512;
    localparam int QDEPTH    = 4096;
    localparam int SCRATCH   = TAG_MAX + 1;
    localparam int CYC_LIMIT = 2000000;

    // scanner phases
    localparam int SC_TEXT      = 0;
    localparam int SC_NAME      = 1;
    localparam int SC_AFTER     = 2;
    localparam int SC_BODY      = 3;
    localparam int SC_LOGREST   = 4;
    localparam int SC_LINESTART = 5;
    localparam int SC_LSP       = 6;
    localparam int SC_LSTAR     = 7;
    localparam int SC_MSKIP     = 8;

    class cmp_scoreboard;
        bit [1:0]     mode;
        int           phase[2];
        bit [7:0]     kwm[2];
        bit [7:0]     held[2][TAG_MAX];
        int           held_n[2];
        bit [8:0]     sym_q[QDEPTH];
        int           q_count, q_head;
        bit           lead;
        bit [1:0]     ended;
        bit [1:0]     verdict;
        int           lit_left[2];
        bit [7:0]     work[SCRATCH];
        bit [7:0]     spare[SCRATCH];
        int           wh, wl;
        bit [1:0]     due_status[$];
        bit           failed;
        string        kw[8];
        string        mark;

        function new();
            kw = '{"Log", "Id", "Revision", "Source", "Author", "Date", "State", "Header"};
            mark = "BK Id: ";
            mode = kbsc_pkg::MODE_EXACT;
            failed = 0;
            restart();
        endfunction

        function void restart();
            for (int f = 0; f < 2; f++) begin
                phase[f] = SC_TEXT;
                kwm[f] = 0;
                held_n[f] = 0;
                lit_left[f] = 0;
            end
            q_count = 0;
            q_head = 0;
            lead = 0;
            ended = 0;
            verdict = kbsc_pkg::ST_BUSY;
            wh = 0;
            wl = 0;
        endfunction

        function void set_mode(bit [1:0] m);
            mode = m;
            restart();
        endfunction

        function void push_sym(int f, bit [8:0] s);
            int idx;
            if (verdict != kbsc_pkg::ST_BUSY) return;
            if (q_count == 0 || lead == f) begin
                if (ended[f ^ 1]) verdict = kbsc_pkg::ST_DIFF;
                else if (q_count >= QDEPTH) verdict = kbsc_pkg::ST_OVF;
                else begin
                    idx = (q_head + q_count) % QDEPTH;
                    sym_q[idx] = s;
                    q_count++;
                    lead = 1'(f);
                end
            end else begin
                if (sym_q[q_head] != s) verdict = kbsc_pkg::ST_DIFF;
                q_head = (q_head + 1) % QDEPTH;
                q_count--;
            end
        endfunction

        function void hold_byte(int f, bit [7:0] b);
            if (held_n[f] < TAG_MAX) begin
                held[f][held_n[f]] = b;
                held_n[f]++;
            end
        endfunction

        // release a failed tag: first three bytes pass, the rest is rescanned
        function void drop_tag(int f, bit has_cur, bit [7:0] cur);
            int n, total, k;
            n = held_n[f];
            total = n + has_cur;
            k = 0;
            for (int i = 0; i < 3 && i < total; i++)
                push_sym(f, i < n ? held[f][i] : cur);
            lit_left[f] = total < 3 ? 3 - total : 0;
            for (int i = 3; i < n && k < SCRATCH; i++) spare[k++] = held[f][i];
            if (has_cur && n >= 3 && k < SCRATCH) spare[k++] = cur;
            for (int i = 0; i < wl && k < SCRATCH && wh + i < SCRATCH; i++)
                spare[k++] = work[wh + i];
            for (int i = 0; i < k; i++) work[i] = spare[i];
            wh = 0;
            wl = k;
            phase[f] = SC_TEXT;
            held_n[f] = 0;
            kwm[f] = 0;
        endfunction

        function void unread(bit [7:0] b);
            if (wh > 0) begin
                wh--;
                work[wh] = b;
                wl++;
            end
        endfunction

        function void tag_token(int f);
            push_sym(f, kbsc_pkg::SYM_TAG_BASE + 9'(kwm[f][2:0]));
            held_n[f] = 0;
            lit_left[f] = 0;
        endfunction

        function void scan_kw(int f, bit [7:0] b);
            int q;
            bit [7:0] nm;
            case (phase[f])
                SC_NAME: begin
                    q = held_n[f] - 1;
                    nm = 0;
                    for (int k = 0; k < 8; k++)
                        if (kwm[f][k] && q < kw[k].len() && kw[k][q] == b) nm[k] = 1;
                    if (nm == 0) drop_tag(f, 1, b);
                    else begin
                        hold_byte(f, b);
                        kwm[f] = nm;
                        for (int k = 0; k < 8; k++)
                            if (nm[k] && kw[k].len() == q + 1) begin
                                kwm[f] = 8'(k);
                                phase[f] = SC_AFTER;
                            end
                    end
                end
                SC_AFTER: begin
                    if (b == "$") begin
                        tag_token(f);
                        phase[f] = SC_TEXT;
                    end else if (b == ":") begin
                        hold_byte(f, b);
                        phase[f] = SC_BODY;
                    end else drop_tag(f, 1, b);
                end
                SC_BODY: begin
                    if (b == 8'h0A) drop_tag(f, 1, b);
                    else if (b == "$") begin
                        tag_token(f);
                        phase[f] = (kwm[f] == 0) ? SC_LOGREST : SC_TEXT;
                    end else if (held_n[f] + 1 > TAG_MAX) drop_tag(f, 1, b);
                    else hold_byte(f, b);
                end
                SC_LOGREST: if (b == 8'h0A) phase[f] = SC_LINESTART;
                SC_LINESTART: begin
                    if (b == "#") phase[f] = SC_LOGREST;
                    else if (b == " ") phase[f] = SC_LSP;
                    else begin
                        phase[f] = SC_TEXT;
                        unread(b);
                    end
                end
                SC_LSP: begin
                    if (b == "*") phase[f] = SC_LSTAR;
                    else begin
                        push_sym(f, 9'h020);
                        phase[f] = SC_TEXT;
                        unread(b);
                    end
                end
                SC_LSTAR: begin
                    if (b == "/") begin
                        push_sym(f, 9'h020);
                        push_sym(f, 9'h02A);
                        phase[f] = SC_TEXT;
                        unread(b);
                    end else if (b == 8'h0A) phase[f] = SC_LINESTART;
                    else phase[f] = SC_LOGREST;
                end
                default: begin
                    phase[f] = SC_TEXT;
                    if (lit_left[f] > 0) begin
                        lit_left[f]--;
                        push_sym(f, {1'b0, b});
                    end else if (b == "$") begin
                        held_n[f] = 0;
                        hold_byte(f, b);
                        kwm[f] = 8'hFF;
                        phase[f] = SC_NAME;
                    end else push_sym(f, {1'b0, b});
                end
            endcase
        endfunction

        function void drain_work(int f);
            bit [7:0] b;
            while (wl > 0 && wh < SCRATCH) begin
                b = work[wh];
                wh++;
                wl--;
                scan_kw(f, b);
            end
            wl = 0;
        endfunction

        function void scan_mark(int f, bit [7:0] b);
            if (phase[f] == SC_MSKIP) begin
                if (b == 8'h0A) begin
                    push_sym(f, {1'b0, b});
                    phase[f] = SC_TEXT;
                    kwm[f] = 0;
                end
                return;
            end
            phase[f] = SC_TEXT;
            push_sym(f, {1'b0, b});
            if (kwm[f] < 7 && b == mark[kwm[f]]) begin
                kwm[f]++;
                if (kwm[f] == 7) begin
                    phase[f] = SC_MSKIP;
                    kwm[f] = 0;
                end
            end else kwm[f] = (b == mark[0]) ? 8'd1 : 8'd0;
        endfunction

        function void close_file(int f);
            if (mode == kbsc_pkg::MODE_KEYWORD) begin
                wh = 0;
                wl = 0;
                forever begin
                    drain_work(f);
                    if (phase[f] >= SC_NAME && phase[f] <= SC_BODY) drop_tag(f, 0, 0);
                    else break;
                end
                if (phase[f] == SC_LSP) push_sym(f, 9'h020);
                else if (phase[f] == SC_LSTAR) begin
                    push_sym(f, 9'h020);
                    push_sym(f, 9'h02A);
                end
            end
            phase[f] = SC_TEXT;
            held_n[f] = 0;
            ended[f] = 1;
            if (verdict != kbsc_pkg::ST_BUSY) return;
            if (ended == 2'b11)
                verdict = (q_count == 0) ? kbsc_pkg::ST_SAME : kbsc_pkg::ST_DIFF;
            else if (q_count > 0 && lead != f) verdict = kbsc_pkg::ST_DIFF;
        endfunction

        function void note_item(bit [1:0] cmd, bit [7:0] b);
            int f;
            f = cmd[0];
            if (verdict == kbsc_pkg::ST_BUSY && !ended[f]) begin
                if (cmd == kbsc_pkg::CMD_BYTE_A || cmd == kbsc_pkg::CMD_BYTE_B) begin
                    if (mode == kbsc_pkg::MODE_KEYWORD) begin
                        work[0] = b;
                        wh = 0;
                        wl = 1;
                        drain_work(f);
                    end else if (mode == kbsc_pkg::MODE_MARKER) scan_mark(f, b);
                    else push_sym(f, {1'b0, b});
                end else close_file(f);
            end
            due_status.push_back(verdict);
        endfunction

        function void check_status(bit [7:0] got);
            bit [1:0] exp_st;
            if (due_status.size() == 0) begin
                $error("status transfer with nothing expected: %0d", got[1:0]);
                failed = 1;
                return;
            end
            exp_st = due_status.pop_front();
            if (got[1:0] !== exp_st) begin
                $error("status: expected %0d, got %0d", exp_st, got[1:0]);
                failed = 1;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [1:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;

    cmp_scoreboard sb;
    bit calm;
    bit squeeze;
    int sent_items;
    int cycles;

    keyword_blind_stream_compare_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYC_LIMIT) begin
                $display("keyword_blind_stream_compare_core: mismatch");
                $finish;
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        stall = 0;
        m_tready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (squeeze) begin
                m_tready <= 0;
                repeat (700) @(negedge aclk);
                squeeze = 0;
            end
            if (stall > 0) begin
                stall--;
                m_tready <= 0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 11) - 1;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_status(m_tdata);
    end

    // called at a falling edge, returns at a falling edge after the transfer
    task automatic send_item(bit [1:0] cmd, bit [7:0] b);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(cmd, b);
        sent_items++;
        @(negedge aclk);
    endtask

    task automatic write_mode(bit [1:0] m);
        s_tvalid <= 0;
        while (sb.due_status.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        cfg_valid <= 1;
        cfg_data  <= m;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_mode(m);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    function automatic void put_text(ref bit [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    endfunction

    function automatic string rand_word(int lo, int hi);
        string s;
        s = "";
        repeat ($urandom_range(lo, hi)) s = {s, string'(8'($urandom_range(8'h61, 8'h7A)))};
        return s;
    endfunction

    // one piece of file text for both files, mostly alike with varied content
    function automatic void add_piece(ref bit [7:0] qa[$], ref bit [7:0] qb[$]);
        string names[8];
        string nm, w;
        int r;
        bit [7:0] x;
        names = '{"Log", "Id", "Revision", "Source", "Author", "Date", "State", "Header"};
        nm = names[$urandom_range(0, 7)];
        r = $urandom_range(0, 11);
        case (r)
            0, 1: begin
                w = rand_word(1, 8);
                put_text(qa, w);
                put_text(qb, w);
                if ($urandom_range(0, 9) == 0) qb[$] = qb[$] ^ 8'h01;
            end
            2: begin
                x = 8'($urandom);
                qa.push_back(x);
                qb.push_back($urandom_range(0, 7) == 0 ? 8'($urandom) : x);
            end
            3, 4: begin
                put_text(qa, $urandom_range(0, 1) ? {"$", nm, "$"} :
                              {"$", nm, ": ", rand_word(0, 6), " $"});
                if ($urandom_range(0, 9) == 0) nm = names[$urandom_range(0, 7)];
                put_text(qb, $urandom_range(0, 1) ? {"$", nm, "$"} :
                              {"$", nm, ": ", rand_word(0, 6), " $"});
            end
            5: begin
                put_text(qa, {"$Log: ", rand_word(0, 4), " $", rand_word(0, 3), "\n"});
                put_text(qb, {"$Log$", rand_word(0, 3), "\n"});
                repeat ($urandom_range(0, 3))
                    put_text(qa, $urandom_range(0, 1) ? {" * ", rand_word(0, 5), "\n"} :
                                  {"#", rand_word(0, 5), "\n"});
                repeat ($urandom_range(0, 2)) put_text(qb, {" *", rand_word(0, 3), "\n"});
                w = $urandom_range(0, 2) == 0 ? " */\n" : ($urandom_range(0, 1) ? " x" : "z");
                put_text(qa, w);
                put_text(qb, w);
            end
            6: begin
                // broken tags: cut name, missing colon, newline in body, bare dollars
                case ($urandom_range(0, 3))
                    0: w = {"$", nm.substr(0, $urandom_range(0, nm.len() - 1)), "q"};
                    1: w = {"$", nm, "x", rand_word(0, 3)};
                    2: w = {"$", nm, ": ", rand_word(0, 4), "\n"};
                    default: w = $urandom_range(0, 1) ? "$$" : "$";
                endcase
                put_text(qa, w);
                put_text(qb, w);
            end
            7, 8: begin
                w = $urandom_range(0, 3) == 0 ? "BK I" : "BK Id: ";
                put_text(qa, {w, rand_word(0, 6), "\n"});
                put_text(qb, {w, rand_word(0, 6), "\n"});
            end
            9: begin
                put_text(qa, "\n");
                put_text(qb, "\n");
            end
            default: begin
                w = $urandom_range(0, 1) ? " *" : "#";
                put_text(qa, {"\n", w});
                put_text(qb, {"\n", w});
            end
        endcase
    endfunction

    // random interleaving in bursts; noise may end a file early
    task automatic run_files(bit [7:0] qa[$], bit [7:0] qb[$], bit noisy);
        int ia, ib, f, n;
        ia = 0;
        ib = 0;
        while (ia < qa.size() || ib < qb.size()) begin
            f = (ia >= qa.size()) ? 1 : (ib >= qb.size()) ? 0 : $urandom_range(0, 1);
            n = $urandom_range(1, 12);
            while (n > 0 && (f == 0 ? ia < qa.size() : ib < qb.size())) begin
                if (noisy && $urandom_range(0, 40) == 0)
                    send_item($urandom_range(0, 1) ? kbsc_pkg::CMD_END_A : kbsc_pkg::CMD_END_B,
                              8'($urandom));
                if (f == 0) send_item(kbsc_pkg::CMD_BYTE_A, qa[ia++]);
                else send_item(kbsc_pkg::CMD_BYTE_B, qb[ib++]);
                n--;
            end
        end
        if ($urandom_range(0, 1)) begin
            send_item(kbsc_pkg::CMD_END_A, 8'($urandom));
            send_item(kbsc_pkg::CMD_END_B, 8'($urandom));
        end else begin
            send_item(kbsc_pkg::CMD_END_B, 8'($urandom));
            send_item(kbsc_pkg::CMD_END_A, 8'($urandom));
        end
    endtask

    task automatic run_pair(bit [1:0] m, string a, string b);
        bit [7:0] qa[$];
        bit [7:0] qb[$];
        put_text(qa, a);
        put_text(qb, b);
        write_mode(m);
        run_files(qa, qb, 0);
    endtask

    initial begin
        bit [7:0] qa[$];
        bit [7:0] qb[$];
        string longbody;
        int sess;
        sb = new();
        calm = 0;
        squeeze = 0;
        sent_items = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        cfg_valid = 0;
        cfg_data = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: byte extremes, early decision, tags, Log at end, marker
        send_item(kbsc_pkg::CMD_BYTE_A, 8'h00);
        send_item(kbsc_pkg::CMD_BYTE_B, 8'h00);
        send_item(kbsc_pkg::CMD_BYTE_B, 8'hFF);
        send_item(kbsc_pkg::CMD_END_B, 8'h00);
        send_item(kbsc_pkg::CMD_BYTE_A, 8'hFF);
        send_item(kbsc_pkg::CMD_END_A, 8'h00);
        send_item(kbsc_pkg::CMD_BYTE_A, 8'h55);
        run_pair(kbsc_pkg::MODE_KEYWORD, "$Id$", "$Id: v $");
        run_pair(kbsc_pkg::MODE_KEYWORD, "$Log$\n *", "$Log: a $\n#x\n *");
        run_pair(kbsc_pkg::MODE_KEYWORD, "$Rev", "$Rev");
        run_pair(kbsc_pkg::MODE_MARKER, "BK Id: a\n", "BK Id: b\n");
        run_pair(2'd3, "$Id$", "$Id: q $");

        // tag body that runs past the holding limit, in one file only
        longbody = "";
        repeat (TAG_MAX + 4) longbody = {longbody, "x"};
        run_pair(kbsc_pkg::MODE_KEYWORD, {"$Id: ", longbody, "$"}, "$Id$");

        sess = 0;
        while (sent_items < 1950) begin
            qa.delete();
            qb.delete();
            repeat ($urandom_range(4, 16)) add_piece(qa, qb);
            write_mode(2'(sess % 4));
            if (sess == 2) squeeze = 1;
            if (sent_items > 1650) calm = 1;
            run_files(qa, qb, $urandom_range(0, 7) == 0);
            sess++;
        end

        s_tvalid <= 0;
        while (sb.due_status.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (!sb.failed && sb.due_status.size() == 0)
            $display("keyword_blind_stream_compare_core: match");
        else
            $display("keyword_blind_stream_compare_core: mismatch");
        $finish;
    end
endmodule

>>> files.f
rtl/kbsc_pkg.sv
rtl/kbsc_align.sv
rtl/kbsc_scan.sv
rtl/keyword_blind_stream_compare_core.sv
tb/tb.sv
